// ===== rtl/md5_hash_engine_macros.svh =====
// ----------------------------------------------------------------------------
// md5_hash_engine_macros.svh
// Assertion shorthands for the MD5 engine. Each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef MD5_HASH_ENGINE_MACROS_SVH
`define MD5_HASH_ENGINE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define MD5_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define MD5_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/md5_pkg.sv =====
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round tables for the MD5 engine.
// ----------------------------------------------------------------------------
package md5_pkg;

  // Four 32-bit chaining words, index 0 is A
  typedef logic [3:0][31:0] md5_chain_t;

  // Control from sequencer to compression core
  typedef struct packed {
    logic start;  // begin compressing the buffered block
    logic init;   // restore initial chaining values
  } md5_cmd_t;

  // Status from compression core
  typedef struct packed {
    logic busy;
    logic done;   // one-cycle pulse, set together with the chaining update
  } md5_stat_t;

  localparam md5_chain_t MD5_IV = {32'h10325476, 32'h98BADCFE,
                                   32'hEFCDAB89, 32'h67452301};

  localparam logic [7:0] MD5_PAD_BYTE = 8'h80;
  localparam logic [5:0] MD5_LEN_POS  = 6'd56;
  localparam logic [5:0] MD5_POS_LAST = 6'd63;
  localparam logic [1:0] MD5_IDX_LAST = 2'd3;

  // Core sequencing: read issue at 0, first round at 2, chain update at 66
  localparam logic [6:0] MD5_CNT_PRE   = 7'd1;
  localparam logic [6:0] MD5_CNT_RND0  = 7'd2;
  localparam logic [6:0] MD5_CNT_RNDN  = 7'd65;
  localparam logic [6:0] MD5_CNT_FINAL = 7'd66;

  localparam logic [31:0] MD5_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Rotate amounts, indexed by {round group, round[1:0]}
  localparam logic [4:0] MD5_S [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22,
    5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23,
    5'd6, 5'd10, 5'd15, 5'd21
  };

  // Message word used by a round
  function automatic logic [3:0] md5_widx(input logic [5:0] rnd);
    logic [7:0] r8;
    logic [7:0] t;
    r8 = {2'b00, rnd};
    case (rnd[5:4])
      2'd0:    t = r8;
      2'd1:    t = r8 * 8'd5 + 8'd1;
      2'd2:    t = r8 * 8'd3 + 8'd5;
      default: t = r8 * 8'd7;
    endcase
    return t[3:0];
  endfunction

  function automatic logic [31:0] md5_rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] t;
    t = {x, x} << s;
    return t[63:32];
  endfunction

endpackage

// ===== rtl/md5_in_if.sv =====
// ----------------------------------------------------------------------------
// md5_in_if
// Message byte channel: one optional byte plus end-of-message flag per item.
// ----------------------------------------------------------------------------
interface md5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       byte_present;
  logic       last_byte;

  modport source (output valid, output msg_byte, output byte_present,
                  output last_byte, input ready);
  modport sink   (input valid, input msg_byte, input byte_present,
                  input last_byte, output ready);
endinterface

// ===== rtl/md5_out_if.sv =====
// ----------------------------------------------------------------------------
// md5_out_if
// Digest channel: one 32-bit chaining word per item, four per message.
// ----------------------------------------------------------------------------
interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

// ===== rtl/md5_blkbuf.sv =====
// ----------------------------------------------------------------------------
// md5_blkbuf
// 64-byte block buffer as 16 x 32-bit words: byte-wide writes and
// registered word reads.
// ----------------------------------------------------------------------------
module md5_blkbuf import md5_pkg::*; (
  input  logic        clk,
  input  logic        wr_en,
  input  logic [5:0]  wr_addr,
  input  logic [7:0]  wr_data,
  input  logic [3:0]  rd_addr,
  output logic [31:0] rd_data
);

  logic [31:0] mem_r [16];
  logic [31:0] rd_data_r;

  // Byte lane write, little-endian within the word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr[5:2]][{wr_addr[1:0], 3'b000} +: 8] <= wr_data;
    end
  end

  // Registered word read
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/md5_core.sv =====
// ----------------------------------------------------------------------------
// md5_core
// MD5 compression: one round per cycle over the block buffer, message words
// fetched ahead and folded with A and K into pre_r before the round needs them.
// ----------------------------------------------------------------------------
module md5_core import md5_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  md5_cmd_t    cmd,
  output md5_stat_t   stat,
  output md5_chain_t  chain,
  output logic [3:0]  rd_addr,
  input  logic [31:0] rd_data
);

  logic       busy_r;
  logic       done_r;
  logic [6:0] cnt_r;
  md5_chain_t chain_r;
  logic [31:0] a_r, b_r, c_r, d_r, pre_r;

  logic [5:0]  rnd;
  logic [5:0]  kidx;
  logic        rnd_en;
  logic [31:0] f_val;
  logic [31:0] sum;
  logic [31:0] pre_base;

  assign rnd    = cnt_r[5:0] - 6'd2;
  assign kidx   = cnt_r[5:0] - 6'd1;
  assign rnd_en = busy_r && (cnt_r >= MD5_CNT_RND0) && (cnt_r <= MD5_CNT_RNDN);

  // Fetch message word for round cnt
  assign rd_addr = md5_widx(cnt_r[5:0]);

  // Round function by group
  always_comb begin
    case (rnd[5:4])
      2'd0:    f_val = (b_r & c_r) | (~b_r & d_r);
      2'd1:    f_val = (d_r & b_r) | (~d_r & c_r);
      2'd2:    f_val = b_r ^ c_r ^ d_r;
      default: f_val = c_r ^ (b_r | ~d_r);
    endcase
  end

  assign sum = pre_r + f_val;

  // Next round's A is current D, except before the first round
  assign pre_base = (cnt_r == MD5_CNT_PRE) ? a_r : d_r;

  // Control and chaining state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      cnt_r   <= '0;
      chain_r <= MD5_IV;
    end else begin
      done_r <= 1'b0;
      if (cmd.init) begin
        chain_r <= MD5_IV;
      end
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == MD5_CNT_FINAL) begin
          busy_r     <= 1'b0;
          done_r     <= 1'b1;
          chain_r[0] <= chain_r[0] + a_r;
          chain_r[1] <= chain_r[1] + b_r;
          chain_r[2] <= chain_r[2] + c_r;
          chain_r[3] <= chain_r[3] + d_r;
        end else begin
          cnt_r <= cnt_r + 7'd1;
        end
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
    end else if (busy_r) begin
      pre_r <= pre_base + MD5_K[kidx] + rd_data;
      if (rnd_en) begin
        a_r <= d_r;
        d_r <= c_r;
        c_r <= b_r;
        b_r <= b_r + md5_rotl(sum, MD5_S[{rnd[5:4], rnd[1:0]}]);
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign chain     = chain_r;

endmodule

// ===== rtl/md5_hash_engine.sv =====
// ----------------------------------------------------------------------------
// md5_hash_engine: up to one byte per item, written to the buffer when accepted;
// input is taken only while idle, not during padding or compression. Each full
// 64-byte block is compressed in 64 rounds. End of message: byte-serial padding,
// one or two compressions, then four digest items.
// Sync active-low reset: IV chaining words, zero count; buffer not cleared.
// ----------------------------------------------------------------------------
`include "md5_hash_engine_macros.svh"

module md5_hash_engine import md5_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  md5_in_if.sink    in_ch,
  md5_out_if.source out_ch
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_COMP, ST_WAIT, ST_PADSET, ST_PAD, ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_MSG, PH_EXTRA, PH_FINAL
  } phase_t;

  state_t      state_r, state_nxt;
  phase_t      phase_r, phase_nxt;
  logic [60:0] total_r, total_nxt;
  logic        pend_r, pend_nxt;
  logic [5:0]  ptr_r, ptr_nxt;
  logic        first_r, first_nxt;
  logic        extra_r, extra_nxt;
  logic [1:0]  idx_r, idx_nxt;

  logic        in_acc;
  logic        out_acc;
  logic        wr_en;
  logic [5:0]  wr_addr;
  logic [7:0]  wr_data;
  logic [3:0]  rd_addr;
  logic [31:0] rd_data;
  logic [63:0] len_bits;
  logic [7:0]  pad_byte;
  md5_cmd_t    core_cmd;
  md5_stat_t   core_stat;
  md5_chain_t  chain;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = (state_r == ST_OUT);
  assign out_acc      = out_ch.valid && out_ch.ready;

  // Padding byte: marker, zero fill, or little-endian bit length
  assign len_bits = {total_r, 3'b000};
  always_comb begin
    if (first_r) begin
      pad_byte = MD5_PAD_BYTE;
    end else if ((ptr_r >= MD5_LEN_POS) && !extra_r) begin
      pad_byte = len_bits[{ptr_r[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // Buffer write port: message bytes when idle, padding bytes while padding
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = total_r[5:0];
    wr_data = in_ch.msg_byte;
    if (state_r == ST_PAD) begin
      wr_en   = 1'b1;
      wr_addr = ptr_r;
      wr_data = pad_byte;
    end else if (in_acc && in_ch.byte_present) begin
      wr_en = 1'b1;
    end
  end

  assign core_cmd.start = (state_r == ST_COMP);
  assign core_cmd.init  = out_acc && (idx_r == MD5_IDX_LAST);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    total_nxt = total_r;
    pend_nxt  = pend_r;
    ptr_nxt   = ptr_r;
    first_nxt = first_r;
    extra_nxt = extra_r;
    idx_nxt   = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.byte_present) begin
            total_nxt = total_r + 61'd1;
          end
          if (in_ch.byte_present && (total_r[5:0] == MD5_POS_LAST)) begin
            state_nxt = ST_COMP;
            phase_nxt = PH_MSG;
            pend_nxt  = in_ch.last_byte;
          end else if (in_ch.last_byte) begin
            state_nxt = ST_PADSET;
          end
        end
      end
      ST_PADSET: begin
        ptr_nxt   = total_r[5:0];
        first_nxt = 1'b1;
        extra_nxt = (total_r[5:0] >= MD5_LEN_POS);
        state_nxt = ST_PAD;
      end
      ST_PAD: begin
        first_nxt = 1'b0;
        if (ptr_r == MD5_POS_LAST) begin
          state_nxt = ST_COMP;
          phase_nxt = extra_r ? PH_EXTRA : PH_FINAL;
        end else begin
          ptr_nxt = ptr_r + 6'd1;
        end
      end
      ST_COMP: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (core_stat.done) begin
          case (phase_r)
            PH_MSG: begin
              state_nxt = pend_r ? ST_PADSET : ST_IDLE;
              pend_nxt  = 1'b0;
            end
            PH_EXTRA: begin
              ptr_nxt   = '0;
              first_nxt = 1'b0;
              extra_nxt = 1'b0;
              state_nxt = ST_PAD;
            end
            default: begin
              idx_nxt   = '0;
              state_nxt = ST_OUT;
            end
          endcase
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          if (idx_r == MD5_IDX_LAST) begin
            total_nxt = '0;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_MSG;
      total_r <= '0;
      pend_r  <= 1'b0;
      ptr_r   <= '0;
      first_r <= 1'b0;
      extra_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      total_r <= total_nxt;
      pend_r  <= pend_nxt;
      ptr_r   <= ptr_nxt;
      first_r <= first_nxt;
      extra_r <= extra_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Digest words straight from the chaining registers, stable until taken
  assign out_ch.digest_word = chain[idx_r];
  assign out_ch.word_index  = idx_r;
  assign out_ch.last_word   = (idx_r == MD5_IDX_LAST);

  md5_blkbuf u_blkbuf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  md5_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (core_cmd),
    .stat    (core_stat),
    .chain   (chain),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Checks
  `MD5_ASSERT_IMPL(a_no_wr_in_comp, core_stat.busy, !wr_en, "buffer written during compression")
  `MD5_ASSERT_IMPL(a_in_out_excl, out_ch.valid, !in_ch.ready, "input taken while digest pending")
  `MD5_ASSERT_NEXT(a_restart_iv, out_acc && out_ch.last_word, (chain == MD5_IV) && (total_r == '0), "state not restored after digest")
  `MD5_ASSERT_NEXT(a_idx_step, out_acc && !out_ch.last_word, out_ch.word_index == $past(out_ch.word_index) + 2'd1, "digest word skipped")

endmodule

// ===== tb/sv/md5_hash_engine_tb.sv =====
// ----------------------------------------------------------------------------
// md5_hash_engine_tb
// Self-checking bench for the streaming MD5 engine. A directed table covers
// the known digests (empty message, "a", "abc"), byte extremes, idle items and
// a separate end marker. Random messages follow, some sized at the one- and
// two-block padding boundaries, under several source/sink throttle phases.
// Every accepted input item updates a local MD5 model and each digest word
// that comes out is checked in order against it.
// ----------------------------------------------------------------------------
module md5_hash_engine_tb import md5_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_ITEMS  = 320;
  localparam int HOLD_CYCLES = 600;
  localparam int TAIL_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;

  // Round constants and per-group rotate amounts
  localparam logic [31:0] MD_ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };
  localparam int unsigned MD_SHIFT [4][4] = '{
    '{7, 12, 17, 22}, '{5, 9, 14, 20}, '{4, 11, 16, 23}, '{6, 10, 15, 21}
  };

  localparam md5_chain_t INIT_CHAIN = {32'h10325476, 32'h98badcfe,
                                       32'hefcdab89, 32'h67452301};
  // Known digests, word 0 in the low bits
  localparam md5_chain_t EMPTY_DIGEST = {32'h7e42f8ec, 32'h980980e9,
                                         32'h04b2008f, 32'hd98c1dd4};
  localparam md5_chain_t A_DIGEST     = {32'h61267769, 32'he299c331,
                                         32'ha8b6f1c0, 32'hb975c10c};
  localparam md5_chain_t ABC_DIGEST   = {32'h727fe128, 32'h7d3f96d6,
                                         32'hb04fd23c, 32'h98500190};
  localparam md5_chain_t NO_DIGEST    = '0;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } digest_word_t;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       present;
    logic       last;
    logic       has_ref;
    md5_chain_t ref_digest;
  } stim_row_t;

  // Directed table: digest typed in only for well-known messages
  localparam int DIR_COUNT = 13;
  localparam stim_row_t DIR_ROWS [DIR_COUNT] = '{
    '{8'h5a, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},  // empty message straight out of reset
    '{8'hff, 1'b0, 1'b0, 1'b0, NO_DIGEST},     // idle item
    '{8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_DIGEST},     // idle inside a message
    '{8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
    '{8'h61, 1'b1, 1'b1, 1'b1, A_DIGEST},      // byte and end on one item
    '{8'h00, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'hff, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'ha5, 1'b0, 1'b1, 1'b0, NO_DIGEST},     // separate end marker
    '{8'hff, 1'b1, 1'b1, 1'b0, NO_DIGEST},
    '{8'h00, 1'b1, 1'b1, 1'b0, NO_DIGEST},
    '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST}   // chain restored after a digest
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic       tx_valid   = 1'b0;
  logic [7:0] tx_byte    = 8'h00;
  logic       tx_present = 1'b0;
  logic       tx_last    = 1'b0;
  logic       rx_ready   = 1'b0;
  logic       rx_hold    = 1'b0;

  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int items_sent    = 0;
  int error_count   = 0;
  int cycle_count   = 0;

  event long_stall_ev;

  // Model state
  logic [31:0] hash_chain [4];
  logic [7:0]  hash_block [64];
  logic [60:0] hash_bytes;

  digest_word_t digest_q [$];

  md5_in_if  in_if ();
  md5_out_if out_if ();

  assign in_if.valid        = tx_valid;
  assign in_if.msg_byte     = tx_byte;
  assign in_if.byte_present = tx_present;
  assign in_if.last_byte    = tx_last;
  assign out_if.ready       = rx_ready;

  md5_hash_engine dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // MD5 model
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void hash_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, sum, t;
    int g;
    for (int i = 0; i < 16; i++)
      w[i] = {hash_block[4*i+3], hash_block[4*i+2], hash_block[4*i+1], hash_block[4*i]};
    a = hash_chain[0];
    b = hash_chain[1];
    c = hash_chain[2];
    d = hash_chain[3];
    for (int r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = r;
        end
        1: begin
          f = (d & b) | (~d & c);
          g = (5 * r + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * r) % 16;
        end
      endcase
      sum = a + f + MD_ROUND_K[r] + w[g];
      t = d;
      d = c;
      c = b;
      b = b + rol32(sum, MD_SHIFT[r / 16][r % 4]);
      a = t;
    end
    hash_chain[0] += a;
    hash_chain[1] += b;
    hash_chain[2] += c;
    hash_chain[3] += d;
  endfunction

  function automatic void hash_restart();
    for (int i = 0; i < 4; i++) hash_chain[i] = INIT_CHAIN[i];
    hash_bytes = '0;
  endfunction

  // Absorb one accepted item; queue the digest words when it ends a message
  function automatic void hash_absorb(input logic [7:0] b, input logic present,
                                      input logic last, input logic has_ref,
                                      input md5_chain_t ref_digest);
    logic [63:0] bit_len;
    int pos;
    digest_word_t exp_word;
    if (present) begin
      pos = int'(hash_bytes[5:0]);
      hash_block[pos] = b;
      hash_bytes = hash_bytes + 1'b1;
      if (pos == 63) hash_compress();
    end
    if (!last) return;
    bit_len = {hash_bytes, 3'b000};
    pos = int'(hash_bytes[5:0]);
    hash_block[pos] = 8'h80;
    pos = pos + 1;
    // no room for the length: finish this block and pad a second one
    if (pos > 56) begin
      while (pos < 64) begin
        hash_block[pos] = 8'h00;
        pos = pos + 1;
      end
      hash_compress();
      pos = 0;
    end
    while (pos < 56) begin
      hash_block[pos] = 8'h00;
      pos = pos + 1;
    end
    for (int i = 0; i < 8; i++) hash_block[56 + i] = bit_len[8*i +: 8];
    hash_compress();
    for (int i = 0; i < 4; i++) begin
      exp_word.digest_word = has_ref ? ref_digest[i] : hash_chain[i];
      exp_word.word_index  = 2'(i);
      exp_word.last_word   = (i == 3);
      digest_q.insert(digest_q.size(), exp_word);
    end
    hash_restart();
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [7:0] b, input logic present, input logic last,
                           input logic has_ref = 1'b0,
                           input md5_chain_t ref_digest = NO_DIGEST);
    while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      tx_valid <= 1'b0;
      @(posedge clk);
    end
    tx_valid   <= 1'b1;
    tx_byte    <= b;
    tx_present <= present;
    tx_last    <= last;
    do @(posedge clk); while (!in_if.ready);
    hash_absorb(b, present, last, has_ref, ref_digest);
    items_sent++;
  endtask

  // Sender pause: drop valid and wait for every digest word
  task automatic wait_drained();
    tx_valid <= 1'b0;
    do @(posedge clk); while (digest_q.size() != 0);
  endtask

  task automatic send_message(input int len);
    logic split_end;
    split_end = (len == 0) || ($urandom_range(0, 1) == 1);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 9) == 0)
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1, (k == len - 1) && !split_end);
    end
    if (split_end) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Sink: random stalls plus one long hold-off
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || rx_hold) begin
      rx_ready <= 1'b0;
    end else begin
      rx_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  initial begin : long_stall
    @(long_stall_ev);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Digest checker
  // ---------------------------------------------------------------------------
  function automatic void report_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    digest_word_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest item: expected none, actual %h/%0d/%b",
                 $time, out_if.digest_word, out_if.word_index, out_if.last_word);
        error_count++;
      end else begin
        want = digest_q.pop_front();
        report_field("digest_word", want.digest_word, out_if.digest_word);
        report_field("word_index", 32'(want.word_index), 32'(out_if.word_index));
        report_field("last_word", 32'(want.last_word), 32'(out_if.last_word));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int rand_base;
    int phase;
    int cur_phase;
    int kind;
    int len;
    int boundary_lens [9];
    boundary_lens = '{55, 56, 57, 63, 64, 65, 119, 120, 128};
    hash_restart();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed table, no throttling
    for (int i = 0; i < DIR_COUNT; i++)
      send_item(DIR_ROWS[i].byte_val, DIR_ROWS[i].present, DIR_ROWS[i].last,
                DIR_ROWS[i].has_ref, DIR_ROWS[i].ref_digest);

    // random messages in four throttle phases
    rand_base = items_sent;
    cur_phase = -1;
    while (items_sent - rand_base < RAND_ITEMS) begin
      phase = (items_sent - rand_base) * 4 / RAND_ITEMS;
      if (phase != cur_phase) begin
        cur_phase = phase;
        case (phase)
          0: begin
            // full-rate sender against a blocked sink: fills the engine
            src_idle_pct = 0;
            snk_stall_pct <= 0;
            -> long_stall_ev;
          end
          1: begin
            src_idle_pct = 78;
            snk_stall_pct <= 0;
          end
          2: begin
            wait_drained();
            src_idle_pct = 0;
            snk_stall_pct <= 78;
          end
          default: begin
            src_idle_pct = 22;
            snk_stall_pct <= 22;
          end
        endcase
      end
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        send_message($urandom_range(0, 12));
      end else if (kind == 6) begin
        send_message(boundary_lens[$urandom_range(0, 8)]);
      end else if (kind <= 8) begin
        send_message($urandom_range(13, 70));
      end else begin
        // idle noise between messages
        len = $urandom_range(1, 4);
        repeat (len) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
    end

    tx_valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    error_count += digest_q.size();
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/md5_pkg.sv
rtl/md5_in_if.sv
rtl/md5_out_if.sv
rtl/md5_blkbuf.sv
rtl/md5_core.sv
rtl/md5_hash_engine.sv
tb/sv/md5_hash_engine_tb.sv
